[rtl/sha1md_pkg.sv]
// ---------------------------------------------------------------------------
// sha1md_pkg
// shared types and constants of the sha-1 digest engine
// ---------------------------------------------------------------------------
package sha1md_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_ROUND,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } vars_type;

   localparam int unsigned NUM_HASH = 5;
   localparam int unsigned NUM_SCHED = 16;

   localparam logic [31:0] H_INIT [NUM_HASH] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [31:0] PAD_WORD = 32'h80000000;

   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [3:0] LAST_SLOT = 4'd15;
   localparam logic [3:0] LEN_HI_SLOT = 4'd14;
   localparam logic [2:0] LAST_INDEX = 3'd4;
   localparam logic [2:0] FULL_COUNT = 3'd4;

endpackage

[rtl/sha1md_round.sv]
// ---------------------------------------------------------------------------
// sha1md_round
// one sha-1 compression round: round function, constant and word add
// ---------------------------------------------------------------------------
module sha1md_round (
   input  logic [6:0]           round_idx,
   input  sha1md_pkg::vars_type cur,
   input  logic [31:0]          sched_word,
   output sha1md_pkg::vars_type nxt
);

   logic [31:0] f;
   logic [31:0] k;
   logic [31:0] t;

   always_comb begin
      if (round_idx < 7'd20) begin
         f = (cur.b & cur.c) | (~cur.b & cur.d);
         k = sha1md_pkg::K_ROUND0;
      end else if (round_idx < 7'd40) begin
         f = cur.b ^ cur.c ^ cur.d;
         k = sha1md_pkg::K_ROUND1;
      end else if (round_idx < 7'd60) begin
         f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
         k = sha1md_pkg::K_ROUND2;
      end else begin
         f = cur.b ^ cur.c ^ cur.d;
         k = sha1md_pkg::K_ROUND3;
      end
      t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + sched_word;
      nxt.a = t;
      nxt.b = cur.a;
      nxt.c = {cur.b[1:0], cur.b[31:2]};
      nxt.d = cur.c;
      nxt.e = cur.d;
   end

endmodule

[rtl/sha1_message_digest.sv]
// ---------------------------------------------------------------------------
// sha1_message_digest
// a word not marked last is taken in idle; the 16th word of each block starts
// a compression on the single round unit, and no input is taken until it ends
// a last word takes the pad and length pushes, one or two compressions, then
// five result beats before the next transaction
// synchronous reset loads the initial hash values and clears length and control
// ---------------------------------------------------------------------------
module sha1_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // data_word
   input  logic [2:0]  req_tuser,   // byte_count
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [2:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast    // last_of_digest
);

   sha1md_pkg::state_type state_ff, state_in;

   logic [31:0]          hash_ff [sha1md_pkg::NUM_HASH];
   logic [31:0]          hash_in [sha1md_pkg::NUM_HASH];
   sha1md_pkg::vars_type vars_ff, vars_in;
   sha1md_pkg::vars_type vars_nxt;
   logic [31:0]          win_ff [sha1md_pkg::NUM_SCHED];
   logic [31:0]          win_in [sha1md_pkg::NUM_SCHED];
   logic [60:0]          len_ff, len_in;
   logic [3:0]           wib_ff, wib_in;
   logic [6:0]           round_ff, round_in;
   logic                 pad_ff, pad_in;
   logic                 hi_ff, hi_in;
   logic                 final_ff, final_in;
   logic [2:0]           out_idx_ff, out_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;
   logic [2:0]           rsp_idx_ff, rsp_idx_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic        push_en;
   logic [31:0] push_word;
   logic        shift_en;
   logic [31:0] shift_word;
   logic [31:0] sched_mix;
   logic [31:0] sched_new;
   logic [2:0]  cnt;
   logic [31:0] keep_mask;
   logic [31:0] pad_bits;
   logic        out_load;

   sha1md_round u_round (
      .round_idx  (round_ff),
      .cur        (vars_ff),
      .sched_word (win_ff[0]),
      .nxt        (vars_nxt)
   );

   assign req_tready = (state_ff == sha1md_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign sched_mix = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign sched_new = {sched_mix[30:0], sched_mix[31]};
   assign cnt       = (req_tuser > sha1md_pkg::FULL_COUNT) ? sha1md_pkg::FULL_COUNT
                                                          : req_tuser;
   assign out_load  = !rsp_valid_ff || rsp_tready;

   // partial last word: keep valid bytes, place pad byte right after them
   always_comb begin
      case (cnt)
         3'd0: begin
            keep_mask = 32'h00000000;
            pad_bits  = 32'h80000000;
         end
         3'd1: begin
            keep_mask = 32'hFF000000;
            pad_bits  = 32'h00800000;
         end
         3'd2: begin
            keep_mask = 32'hFFFF0000;
            pad_bits  = 32'h00008000;
         end
         3'd3: begin
            keep_mask = 32'hFFFFFF00;
            pad_bits  = 32'h00000080;
         end
         default: begin
            keep_mask = 32'hFFFFFFFF;
            pad_bits  = 32'h00000000;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      vars_in      = vars_ff;
      len_in       = len_ff;
      wib_in       = wib_ff;
      round_in     = round_ff;
      pad_in       = pad_ff;
      hi_in        = hi_ff;
      final_in     = final_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      push_en      = 1'b0;
      push_word    = 32'h0;

      case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               push_en = 1'b1;
               if (!req_tlast) begin
                  push_word = req_tdata;
                  len_in    = len_ff + 61'd4;
               end else begin
                  len_in   = len_ff + 61'(cnt);
                  final_in = 1'b1;
                  state_in = sha1md_pkg::ST_FILL;
                  if (cnt == sha1md_pkg::FULL_COUNT) begin
                     push_word = req_tdata;
                     pad_in    = 1'b1;
                  end else begin
                     push_word = (req_tdata & keep_mask) | pad_bits;
                  end
               end
            end
         end
         sha1md_pkg::ST_FILL: begin
            push_en = 1'b1;
            if (pad_ff) begin
               push_word = sha1md_pkg::PAD_WORD;
               pad_in    = 1'b0;
            end else if (wib_ff == sha1md_pkg::LEN_HI_SLOT) begin
               push_word = len_ff[60:29];
               hi_in     = 1'b1;
            end else if (wib_ff == sha1md_pkg::LAST_SLOT && hi_ff) begin
               push_word = {len_ff[28:0], 3'b000};
            end else begin
               push_word = 32'h0;
            end
         end
         sha1md_pkg::ST_ROUND: begin
            vars_in  = vars_nxt;
            round_in = round_ff + 7'd1;
            if (round_ff == sha1md_pkg::LAST_ROUND) begin
               round_in   = 7'd0;
               hash_in[0] = hash_ff[0] + vars_nxt.a;
               hash_in[1] = hash_ff[1] + vars_nxt.b;
               hash_in[2] = hash_ff[2] + vars_nxt.c;
               hash_in[3] = hash_ff[3] + vars_nxt.d;
               hash_in[4] = hash_ff[4] + vars_nxt.e;
               if (!final_ff) begin
                  state_in = sha1md_pkg::ST_IDLE;
               end else if (hi_ff) begin
                  state_in = sha1md_pkg::ST_OUTPUT;
               end else begin
                  state_in = sha1md_pkg::ST_FILL;
               end
            end
         end
         sha1md_pkg::ST_OUTPUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hash_ff[out_idx_ff];
               rsp_idx_in   = out_idx_ff;
               rsp_last_in  = (out_idx_ff == sha1md_pkg::LAST_INDEX);
               out_idx_in   = out_idx_ff + 3'd1;
               if (out_idx_ff == sha1md_pkg::LAST_INDEX) begin
                  out_idx_in = 3'd0;
                  hash_in    = sha1md_pkg::H_INIT;
                  len_in     = 61'd0;
                  wib_in     = 4'd0;
                  hi_in      = 1'b0;
                  final_in   = 1'b0;
                  state_in   = sha1md_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha1md_pkg::ST_IDLE;
         end
      endcase

      // a push into the last slot completes a block
      if (push_en) begin
         wib_in = wib_ff + 4'd1;
         if (wib_ff == sha1md_pkg::LAST_SLOT) begin
            state_in = sha1md_pkg::ST_ROUND;
            vars_in  = '{a: hash_ff[0], b: hash_ff[1], c: hash_ff[2],
                         d: hash_ff[3], e: hash_ff[4]};
         end
      end
   end

   // message schedule window: win[0] is the word of the current round
   assign shift_en   = push_en || (state_ff == sha1md_pkg::ST_ROUND);
   assign shift_word = push_en ? push_word : sched_new;

   always_comb begin
      for (int i = 0; i < 15; i++) begin
         win_in[i] = shift_en ? win_ff[i + 1] : win_ff[i];
      end
      win_in[15] = shift_en ? shift_word : win_ff[15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1md_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= sha1md_pkg::H_INIT;
         len_ff       <= 61'd0;
         wib_ff       <= 4'd0;
         round_ff     <= 7'd0;
         pad_ff       <= 1'b0;
         hi_ff        <= 1'b0;
         final_ff     <= 1'b0;
         out_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         len_ff       <= len_in;
         wib_ff       <= wib_in;
         round_ff     <= round_in;
         pad_ff       <= pad_in;
         hi_ff        <= hi_in;
         final_ff     <= final_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff     <= vars_in;
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTH
   a_round_start_block_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1md_pkg::ST_ROUND && round_ff == 7'd0) |-> (wib_ff == 4'd0))
      else $error("compression started without a full block");

   a_no_accept_during_final: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !final_ff)
      else $error("transaction accepted while a digest is pending");

   a_restore_after_digest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1md_pkg::ST_OUTPUT && out_load &&
       out_idx_ff == sha1md_pkg::LAST_INDEX)
      |=> (state_ff == sha1md_pkg::ST_IDLE && len_ff == 61'd0 && wib_ff == 4'd0))
      else $error("state not restored after last digest word");

   a_round_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sha1md_pkg::ST_ROUND) |-> (round_ff == 7'd0))
      else $error("round counter active outside compression");
`endif

endmodule
